/* src/jfx_pkg.sv */
// Package for the JSON field value extractor.
// Holds payload structs, state enums, character and status codes and helpers.
// No dependencies.
package jfx_pkg;

   localparam int KEY_MAX_DEF   = 16;
   localparam int NEST_BITS_DEF = 16;

   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_NL       = 8'h0A;
   localparam logic [7:0] CH_VT       = 8'h0B;
   localparam logic [7:0] CH_FF       = 8'h0C;
   localparam logic [7:0] CH_CR       = 8'h0D;

   localparam logic [2:0] ST_FOUND   = 3'd0;
   localparam logic [2:0] ST_MISSING = 3'd1;
   localparam logic [2:0] ST_NOCOLON = 3'd2;
   localparam logic [2:0] ST_NOVALUE = 3'd3;
   localparam logic [2:0] ST_UNTERM  = 3'd4;

   localparam logic [1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [1:0] CSR_KEY_LEN  = 2'd2;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_COLON,
      PH_SKIPWS,
      PH_STRING,
      PH_NEST,
      PH_BARE,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BARE,
      KIND_STRING,
      KIND_OBJECT,
      KIND_ARRAY
   } kind_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       byte_valid;
      logic       done_res;
      logic [2:0] status;
   } rsp_payload_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   function automatic logic is_ws(input logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
   endfunction

   function automatic logic is_bare_end(input logic [7:0] c);
      return c inside {CH_COMMA, CH_RBRACE, CH_RBRACKET, CH_NL, CH_SPACE, CH_TAB};
   endfunction

endpackage

/* src/jfx_cell.sv */
// One cell of the key match chain: holds one recent text byte and its valid bit.
// Compares the byte it takes in against its place in the quoted key pattern.
// Depends on jfx_pkg.
module jfx_cell import jfx_pkg::*; #(
   parameter int KEY_MAX  = KEY_MAX_DEF,
   parameter int CELL_IDX = 0,
   localparam int LEN_W   = $clog2(KEY_MAX + 1),
   localparam int KIDX_W  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctl_type              ctl,
   input  logic [7:0]                byte_in,
   input  logic                      valid_in,
   input  logic [KEY_MAX-1:0][7:0]   key_bytes,
   input  logic [LEN_W-1:0]          key_len,
   output logic [7:0]                byte_out,
   output logic                      valid_out,
   output logic                      match
);

   localparam int CW = $clog2(KEY_MAX + 2);
   localparam logic [CW-1:0] POS = CW'(CELL_IDX);

   logic [7:0]    byte_ff;
   logic          valid_ff;
   logic [CW-1:0] len_ext;
   logic [CW-1:0] open_pos;
   logic [CW-1:0] kidx;
   logic [7:0]    pattern;
   logic          in_use;

   always_comb begin
      len_ext  = CW'(key_len);
      open_pos = len_ext + CW'(1);
      kidx     = len_ext - POS;
      in_use   = (POS <= open_pos);
      if ((POS == '0) || (POS == open_pos)) begin
         pattern = CH_QUOTE;
      end else begin
         pattern = key_bytes[kidx[KIDX_W-1:0]];
      end
      match = !in_use || (valid_in && (byte_in == pattern));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out  = byte_ff;
   assign valid_out = valid_ff;

endmodule

/* src/jfx_parse.sv */
// Phase sequencer: key search, colon search, whitespace skip and value streaming.
// Produces one result item per accepted byte where the text calls for it.
// Depends on jfx_pkg.
module jfx_parse import jfx_pkg::*; #(
   parameter int NEST_BITS = NEST_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type req,
   input  logic            key_hit,
   output cell_ctl_type    cell_ctl,
   output logic            push,
   output rsp_payload_type result
);

   phase_type            phase_ff, phase_in;
   kind_type             kind_ff, kind_in;
   logic [NEST_BITS-1:0] nest_ff, nest_in;
   logic [NEST_BITS-1:0] nest_dec;
   logic [7:0]           c;
   logic [7:0]           open_ch;
   logic [7:0]           close_ch;
   logic                 last;
   logic                 bv;
   logic                 done;
   logic [2:0]           st;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         kind_ff  <= KIND_BARE;
         nest_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         nest_ff  <= nest_in;
      end
   end

   always_comb begin
      c        = req.text_byte;
      last     = req.is_last;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      nest_in  = nest_ff;
      bv       = 1'b0;
      done     = 1'b0;
      st       = ST_FOUND;
      open_ch  = (kind_ff == KIND_OBJECT) ? CH_LBRACE : CH_LBRACKET;
      close_ch = (kind_ff == KIND_OBJECT) ? CH_RBRACE : CH_RBRACKET;
      nest_dec = (nest_ff != '0) ? (nest_ff - NEST_BITS'(1)) : '0;

      case (phase_ff)
         PH_SEARCH: begin
            if (key_hit) begin
               phase_in = PH_COLON;
               if (last) begin
                  done = 1'b1;
                  st   = ST_NOCOLON;
               end
            end else if (last) begin
               done = 1'b1;
               st   = ST_MISSING;
            end
         end
         PH_COLON: begin
            if (c == CH_COLON) begin
               phase_in = PH_SKIPWS;
               if (last) begin
                  done = 1'b1;
                  st   = ST_NOVALUE;
               end
            end else if (last) begin
               done = 1'b1;
               st   = ST_NOCOLON;
            end
         end
         PH_SKIPWS: begin
            if (is_ws(c)) begin
               if (last) begin
                  done = 1'b1;
                  st   = ST_NOVALUE;
               end
            end else if (c == CH_QUOTE) begin
               phase_in = PH_STRING;
               kind_in  = KIND_STRING;
               if (last) begin
                  done = 1'b1;
                  st   = ST_UNTERM;
               end
            end else if ((c == CH_LBRACE) || (c == CH_LBRACKET)) begin
               phase_in = PH_NEST;
               kind_in  = (c == CH_LBRACE) ? KIND_OBJECT : KIND_ARRAY;
               nest_in  = NEST_BITS'(1);
               bv       = 1'b1;
               if (last) begin
                  done = 1'b1;
                  st   = ST_UNTERM;
               end
            end else if (is_bare_end(c)) begin
               done = 1'b1;
               st   = ST_FOUND;
            end else begin
               phase_in = PH_BARE;
               kind_in  = KIND_BARE;
               bv       = 1'b1;
               if (last) begin
                  done = 1'b1;
                  st   = ST_FOUND;
               end
            end
         end
         PH_STRING: begin
            if (c == CH_QUOTE) begin
               done = 1'b1;
               st   = ST_FOUND;
            end else begin
               bv = 1'b1;
               if (last) begin
                  done = 1'b1;
                  st   = ST_UNTERM;
               end
            end
         end
         PH_NEST: begin
            bv = 1'b1;
            if (c == open_ch) begin
               if (nest_ff == '1) begin
                  done = 1'b1;
                  st   = ST_UNTERM;
               end else begin
                  nest_in = nest_ff + NEST_BITS'(1);
               end
            end else if (c == close_ch) begin
               nest_in = nest_dec;
               if (nest_dec == '0) begin
                  done = 1'b1;
                  st   = ST_FOUND;
               end
            end
            if (!done && last) begin
               done = 1'b1;
               st   = ST_UNTERM;
            end
         end
         PH_BARE: begin
            if (is_bare_end(c)) begin
               done = 1'b1;
               st   = ST_FOUND;
            end else begin
               bv = 1'b1;
               if (last) begin
                  done = 1'b1;
                  st   = ST_FOUND;
               end
            end
         end
         default: begin
         end
      endcase

      if (done) begin
         phase_in = PH_DONE;
      end
      if (last) begin
         phase_in = PH_SEARCH;
         kind_in  = KIND_BARE;
         nest_in  = '0;
      end
      if (!accept) begin
         phase_in = phase_ff;
         kind_in  = kind_ff;
         nest_in  = nest_ff;
      end

      cell_ctl.shift    = accept && (phase_ff == PH_SEARCH);
      cell_ctl.clear    = accept && last;
      push              = accept && (bv || done);
      result.value_byte = bv ? c : 8'h00;
      result.byte_valid = bv;
      result.done_res   = done;
      result.status     = done ? st : ST_FOUND;
   end

endmodule

/* src/jfx_out.sv */
// Result stage: output register with a skid register behind it.
// Takes a new item while the registered one waits on stall.
// Depends on jfx_pkg.
module jfx_out import jfx_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_payload_type push_data,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data,
   output logic            full
);

   logic            head_valid_ff, head_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type head_ff, head_in;
   rsp_payload_type skid_ff, skid_in;
   logic            pop;

   always_comb begin
      pop           = head_valid_ff && !rsp_stall;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end else begin
            head_valid_in = 1'b1;
            head_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = head_valid_ff;
   assign rsp_data  = head_ff;
   assign full      = skid_valid_ff;

endmodule

/* src/json_field_value_extractor.sv */
// Result items enter the output register, or the skid register while that one stalls.
// Throughput: one text byte per cycle while req_stall is low; the key match is a chain
// of KEY_MAX + 2 cells compared in parallel; the result stage has one skid register.
// Reset (synchronous): clears key registers, cell valid bits, phase and nesting count;
// no clearing pass, the block takes bytes from the first cycle after reset.
module json_field_value_extractor import jfx_pkg::*; #(
   parameter int KEY_MAX   = KEY_MAX_DEF,
   parameter int NEST_BITS = NEST_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [63:0]     csr_wdata
);

   localparam int DEPTH = KEY_MAX + 2;
   localparam int LEN_W = $clog2(KEY_MAX + 1);

   logic [63:0]              key_low_ff;
   logic [63:0]              key_high_ff;
   logic [4:0]               key_len_ff;
   logic [KEY_MAX-1:0][7:0]  key_bytes;
   logic [LEN_W-1:0]         key_len;
   logic [DEPTH-1:0][7:0]    cell_byte;
   logic [DEPTH-1:0]         cell_valid;
   logic [DEPTH-1:0]         cell_match;
   cell_ctl_type             cell_ctl;
   logic                     accept;
   logic                     push;
   rsp_payload_type          result;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            CSR_KEY_LEN:  key_len_ff  <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   assign key_len = (32'(key_len_ff) > KEY_MAX) ? LEN_W'(KEY_MAX) : LEN_W'(key_len_ff);

   for (genvar j = 0; j < KEY_MAX; j++) begin : g_key
      if (j < 8) begin : g_low
         assign key_bytes[j] = key_low_ff[8*j +: 8];
      end else begin : g_high
         assign key_bytes[j] = key_high_ff[8*(j-8) +: 8];
      end
   end

   assign accept = req_valid && !req_stall;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [7:0] byte_in;
      logic       valid_in;
      if (i == 0) begin : g_head
         assign byte_in  = req_data.text_byte;
         assign valid_in = 1'b1;
      end else begin : g_body
         assign byte_in  = cell_byte[i-1];
         assign valid_in = cell_valid[i-1];
      end
      jfx_cell #(
         .KEY_MAX  (KEY_MAX),
         .CELL_IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .byte_in   (byte_in),
         .valid_in  (valid_in),
         .key_bytes (key_bytes),
         .key_len   (key_len),
         .byte_out  (cell_byte[i]),
         .valid_out (cell_valid[i]),
         .match     (cell_match[i])
      );
   end

   jfx_parse #(
      .NEST_BITS (NEST_BITS)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .key_hit  (&cell_match),
      .cell_ctl (cell_ctl),
      .push     (push),
      .result   (result)
   );

   jfx_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .full      (req_stall)
   );

`ifndef SYNTHESIS
   a_stall_has_head: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid holds an item while the output register is empty");

   a_item_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_valid || rsp_data.done_res))
      else $error("result item carries neither a byte nor a status");

   a_status_with_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.done_res) |-> (rsp_data.status == ST_FOUND))
      else $error("status set on an item that is not the final one");

   a_last_clears_chain: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.is_last) |=> !cell_valid[0])
      else $error("match chain not cleared after the final byte");
`endif

endmodule

/* verif/json_field_value_extractor_test.sv */
// Self-checking testbench for the JSON field value extractor: streams JSON texts,
// predicts every value byte and final status, and compares each result item.
// Depends on jfx_pkg and json_field_value_extractor from the RTL.
`timescale 1ns / 100ps

module json_field_value_extractor_test import jfx_pkg::*; ();

   localparam int          DEPTH       = KEY_MAX_DEF + 2;
   localparam logic [31:0] NEST_LIMIT  = (32'd1 << NEST_BITS_DEF) - 32'd1;
   localparam int          QUIET_LIMIT = 4000;
   localparam int          PHASE_BYTES = 180;
   localparam int          SETTINGS_N  = 8;

   class value_scoreboard;
      logic [63:0]     key_lo;
      logic [63:0]     key_hi;
      logic [4:0]      key_len;
      phase_type       ph;
      logic [7:0]      recent [DEPTH];
      int              seen;
      logic [31:0]     nest;
      kind_type        kind;
      rsp_payload_type expected_values[$];
      int              failures;
      int              items_seen;
      int              results_checked;

      function new();
         key_lo = '0;
         key_hi = '0;
         key_len = '0;
         failures = 0;
         items_seen = 0;
         results_checked = 0;
         clear_text();
      endfunction

      function void clear_text();
         ph = PH_SEARCH;
         foreach (recent[i]) recent[i] = 8'h00;
         seen = 0;
         nest = '0;
         kind = KIND_BARE;
      endfunction

      function void write_reg(logic [1:0] idx, logic [63:0] d);
         case (idx)
            CSR_KEY_LOW: key_lo = d;
            CSR_KEY_HIGH: key_hi = d;
            CSR_KEY_LEN: key_len = d[4:0];
            default: ;
         endcase
      endfunction

      function int outstanding();
         return expected_values.size();
      endfunction

      function bit blank_char(logic [7:0] c);
         return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
                c == CH_FF || c == CH_CR;
      endfunction

      function bit bare_stop(logic [7:0] c);
         return c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACKET || c == CH_NL ||
                c == CH_SPACE || c == CH_TAB;
      endfunction

      function bit key_found();
         int len;
         int plen;
         int i;
         logic [7:0] want;
         len = (key_len > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(key_len);
         plen = len + 2;
         if (seen < plen) return 0;
         for (i = 0; i < plen; i++) begin
            if (i == 0 || i == len + 1) want = CH_QUOTE;
            else if (i - 1 < 8) want = key_lo[(i - 1) * 8 +: 8];
            else want = key_hi[(i - 9) * 8 +: 8];
            if (recent[plen - 1 - i] != want) return 0;
         end
         return 1;
      endfunction

      function void note_text_byte(req_payload_type item);
         logic [7:0]      c;
         logic [7:0]      open_c;
         logic [7:0]      close_c;
         logic            last;
         logic            bv;
         logic            done;
         logic [2:0]      st;
         rsp_payload_type want;
         int              i;
         c = item.text_byte;
         last = item.is_last;
         bv = 1'b0;
         done = 1'b0;
         st = ST_FOUND;
         items_seen++;
         case (ph)
            PH_SEARCH: begin
               for (i = DEPTH - 1; i > 0; i--) recent[i] = recent[i - 1];
               recent[0] = c;
               if (seen < DEPTH) seen++;
               if (key_found()) begin
                  ph = PH_COLON;
                  if (last) begin
                     done = 1'b1;
                     st = ST_NOCOLON;
                  end
               end else if (last) begin
                  done = 1'b1;
                  st = ST_MISSING;
               end
            end
            PH_COLON: begin
               if (c == CH_COLON) begin
                  ph = PH_SKIPWS;
                  if (last) begin
                     done = 1'b1;
                     st = ST_NOVALUE;
                  end
               end else if (last) begin
                  done = 1'b1;
                  st = ST_NOCOLON;
               end
            end
            PH_SKIPWS: begin
               if (blank_char(c)) begin
                  if (last) begin
                     done = 1'b1;
                     st = ST_NOVALUE;
                  end
               end else if (c == CH_QUOTE) begin
                  ph = PH_STRING;
                  kind = KIND_STRING;
                  if (last) begin
                     done = 1'b1;
                     st = ST_UNTERM;
                  end
               end else if (c == CH_LBRACE || c == CH_LBRACKET) begin
                  ph = PH_NEST;
                  kind = (c == CH_LBRACE) ? KIND_OBJECT : KIND_ARRAY;
                  nest = 32'd1;
                  bv = 1'b1;
                  if (last) begin
                     done = 1'b1;
                     st = ST_UNTERM;
                  end
               end else if (bare_stop(c)) begin
                  done = 1'b1;
                  st = ST_FOUND;
               end else begin
                  ph = PH_BARE;
                  kind = KIND_BARE;
                  bv = 1'b1;
                  if (last) begin
                     done = 1'b1;
                     st = ST_FOUND;
                  end
               end
            end
            PH_STRING: begin
               if (c == CH_QUOTE) begin
                  done = 1'b1;
                  st = ST_FOUND;
               end else begin
                  bv = 1'b1;
                  if (last) begin
                     done = 1'b1;
                     st = ST_UNTERM;
                  end
               end
            end
            PH_NEST: begin
               open_c = (kind == KIND_OBJECT) ? CH_LBRACE : CH_LBRACKET;
               close_c = (kind == KIND_OBJECT) ? CH_RBRACE : CH_RBRACKET;
               bv = 1'b1;
               if (c == open_c) begin
                  if (nest >= NEST_LIMIT) begin
                     done = 1'b1;
                     st = ST_UNTERM;
                  end else begin
                     nest++;
                  end
               end else if (c == close_c) begin
                  if (nest > 0) nest--;
                  if (nest == 0) begin
                     done = 1'b1;
                     st = ST_FOUND;
                  end
               end
               if (!done && last) begin
                  done = 1'b1;
                  st = ST_UNTERM;
               end
            end
            PH_BARE: begin
               if (bare_stop(c)) begin
                  done = 1'b1;
                  st = ST_FOUND;
               end else begin
                  bv = 1'b1;
                  if (last) begin
                     done = 1'b1;
                     st = ST_FOUND;
                  end
               end
            end
            default: ;
         endcase
         if (done) ph = PH_DONE;
         if (last) clear_text();
         if (bv || done) begin
            want.value_byte = bv ? c : 8'h00;
            want.byte_valid = bv;
            want.done_res = done;
            want.status = done ? st : ST_FOUND;
            expected_values.push_back(want);
         end
      endfunction

      function void check_value_item(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_values.size() == 0) begin
            $error("result item %h arrived with nothing expected", got);
            failures++;
            return;
         end
         want = expected_values.pop_front();
         results_checked++;
         if (got.value_byte !== want.value_byte) begin
            $error("value_byte: expected %h, got %h", want.value_byte, got.value_byte);
            failures++;
         end
         if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
            failures++;
         end
         if (got.done_res !== want.done_res) begin
            $error("done_res: expected %b, got %b", want.done_res, got.done_res);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_we = 1'b0;
   logic [1:0]      csr_index = CSR_KEY_LOW;
   logic [63:0]     csr_wdata = '0;

   value_scoreboard value_sb = new();
   int              gap_pct = 0;
   int              stall_pct = 0;
   int              texts_sent = 0;
   int              quiet_cycles = 0;
   logic [63:0]     cur_lo = '0;
   logic [63:0]     cur_hi = '0;
   int              cur_len = 0;

   json_field_value_extractor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) value_sb.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) value_sb.note_text_byte(req_data);
         if (rsp_valid && !rsp_stall) value_sb.check_value_item(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("json_field_value_extractor regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] key_char(int j);
      return (j < 8) ? cur_lo[j * 8 +: 8] : cur_hi[(j - 8) * 8 +: 8];
   endfunction

   function automatic logic [63:0] letter_word();
      logic [63:0] w;
      int          j;
      for (j = 0; j < 8; j++) w[j * 8 +: 8] = 8'($urandom_range(122, 97));
      return w;
   endfunction

   function automatic logic [7:0] filler();
      case ($urandom_range(9))
         0: return 8'($urandom_range(255));
         1: return CH_QUOTE;
         2: return CH_COLON;
         3: return CH_COMMA;
         4: return ($urandom_range(1) == 0) ? CH_LBRACE : CH_RBRACKET;
         default: return 8'($urandom_range(126, 32));
      endcase
   endfunction

   function automatic void make_text(ref logic [7:0] t[$]);
      int         j;
      int         n;
      int         depth;
      logic [7:0] open_c;
      logic [7:0] close_c;
      logic [7:0] b;
      t.delete();
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(6, 1);
         for (j = 0; j < n; j++) t.push_back(8'($urandom_range(255)));
         return;
      end
      n = $urandom_range(3);
      for (j = 0; j < n; j++) t.push_back(filler());
      if ($urandom_range(4) == 0) begin
         t.push_back(CH_QUOTE);
         n = $urandom_range(cur_len);
         for (j = 0; j < n; j++) t.push_back(key_char(j));
      end
      if ($urandom_range(99) < 88) begin
         t.push_back(CH_QUOTE);
         for (j = 0; j < cur_len; j++) t.push_back(key_char(j));
         t.push_back(CH_QUOTE);
         if ($urandom_range(9) == 0) t.push_back(filler());
         if ($urandom_range(99) < 92) t.push_back(CH_COLON);
         n = $urandom_range(2);
         for (j = 0; j < n; j++) begin
            case ($urandom_range(5))
               0: b = CH_SPACE;
               1: b = CH_TAB;
               2: b = CH_NL;
               3: b = CH_VT;
               4: b = CH_FF;
               default: b = CH_CR;
            endcase
            t.push_back(b);
         end
         case ($urandom_range(4))
            0: begin
               t.push_back(CH_QUOTE);
               n = $urandom_range(6);
               for (j = 0; j < n; j++) begin
                  b = 8'($urandom_range(255));
                  t.push_back((b == CH_QUOTE) ? 8'h27 : b);
               end
               if ($urandom_range(7) != 0) t.push_back(CH_QUOTE);
            end
            1, 2: begin
               open_c = ($urandom_range(1) == 0) ? CH_LBRACE : CH_LBRACKET;
               close_c = (open_c == CH_LBRACE) ? CH_RBRACE : CH_RBRACKET;
               t.push_back(open_c);
               depth = 1;
               n = $urandom_range(8);
               for (j = 0; j < n; j++) begin
                  case ($urandom_range(4))
                     0: begin
                        t.push_back(open_c);
                        depth++;
                     end
                     1: if (depth > 1) begin
                        t.push_back(close_c);
                        depth--;
                     end
                     default: t.push_back(filler());
                  endcase
               end
               if ($urandom_range(7) != 0) begin
                  for (j = 0; j < depth; j++) t.push_back(close_c);
               end
            end
            default: begin
               n = $urandom_range(5);
               for (j = 0; j < n; j++) t.push_back(8'($urandom_range(122, 48)));
               if ($urandom_range(3) != 0) begin
                  case ($urandom_range(5))
                     0: b = CH_COMMA;
                     1: b = CH_RBRACE;
                     2: b = CH_RBRACKET;
                     3: b = CH_NL;
                     4: b = CH_SPACE;
                     default: b = CH_TAB;
                  endcase
                  t.push_back(b);
               end
            end
         endcase
      end
      n = $urandom_range(3);
      for (j = 0; j < n; j++) t.push_back(filler());
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(t.size(), 1);
         while (t.size() > n) void'(t.pop_back());
      end
      if (t.size() == 0) t.push_back(filler());
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic fin);
      bit taken;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= req_payload_type'{text_byte: b, is_last: fin};
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
         @(negedge clock);
      end
   endtask

   task automatic send_text(input logic [7:0] t[$], input bit fin);
      int i;
      for (i = 0; i < t.size(); i++) send_byte(t[i], fin && i == t.size() - 1);
      texts_sent++;
   endtask

   task automatic send_str(input string s, input bit fin);
      logic [7:0] t[$];
      int         i;
      for (i = 0; i < s.len(); i++) t.push_back(s[i]);
      send_text(t, fin);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (value_sb.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_key(input logic [63:0] lo, input logic [63:0] hi,
                          input logic [63:0] len_word);
      csr_we <= 1'b1;
      csr_index <= CSR_KEY_LOW;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= CSR_KEY_HIGH;
      csr_wdata <= hi;
      @(negedge clock);
      csr_index <= CSR_KEY_LEN;
      csr_wdata <= len_word;
      @(negedge clock);
      csr_we <= 1'b0;
      cur_lo = lo;
      cur_hi = hi;
      cur_len = (len_word[4:0] > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(len_word[4:0]);
   endtask

   initial begin
      int         p;
      int         sent;
      logic [7:0] t[$];
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_key(64'd0, 64'd0, 64'd0);
      send_str("\"\":1", 1'b1);
      drain();
      set_key(64'h6B, 64'd0, 64'd1);
      send_str("\"k\"x", 1'b1);
      send_str("\"k\":", 1'b1);
      send_str("\"k\": ,", 1'b1);
      send_str("\"k\":[1", 1'b1);
      send_str("\"k\":\"a", 1'b1);
      send_str("\"k", 1'b0);
      drain();
      set_key(64'h6B6B, 64'd0, 64'd2);
      send_str("k\":7", 1'b1);

      send_str("\"kk\":", 1'b0);
      send_byte(8'h7A, 1'b1);
      drain();

      for (p = 0; p < SETTINGS_N; p++) begin
         case (p)
            0: set_key(64'd0, 64'd0, 64'd0);
            1: set_key(letter_word(), 64'd0, 64'd3);
            2: set_key('1, '1, 64'd16);
            3: set_key(letter_word(), letter_word(), 64'd31);
            4: set_key({$urandom, $urandom}, {$urandom, $urandom},
                       64'($urandom_range(16)));
            5: set_key(letter_word(), 64'd0, 64'd1);
            6: set_key(letter_word(), letter_word(), 64'hFFFF_FFFF_FFFF_FFE9);
            default: set_key(letter_word(), letter_word(), 64'd17);
         endcase
         case (p % 4)
            0: begin
               gap_pct = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct = 56;
               stall_pct = 0;
            end
            2: begin
               gap_pct = 0;
               stall_pct = 56;
            end
            default: begin
               gap_pct = 16;
               stall_pct = 16;
            end
         endcase
         sent = 0;
         while (sent < PHASE_BYTES) begin
            make_text(t);
            sent += t.size();
            send_text(t, 1'b1);
         end
         drain();
         gap_pct = 0;
         stall_pct = 0;
      end

      repeat (8) @(negedge clock);
      $display("Ran %0d texts, %0d bytes, over %0d key settings and four idle mixes,",
               texts_sent, value_sb.items_seen, SETTINGS_N + 3);
      $display("with short edge-case texts up front; %0d result items compared.",
               value_sb.results_checked);
      if (value_sb.failures == 0) begin
         $display("json_field_value_extractor regression: pass");
      end else begin
         $display("json_field_value_extractor regression: fail");
      end
      $finish;
   end

endmodule
